@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the grid interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GVI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GVI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/gvi_pkg.sv @@
// Types, constants and sizes shared by the grid interpolator modules.
`timescale 1ns / 1ps
`default_nettype none

package gvi_pkg;

	localparam int GRID_NX       = 64;
	localparam int GRID_NY       = 64;
	localparam int GRID_NZ       = 32;
	localparam int POS_FRAC_BITS = 8;
	localparam int POS_SCALE     = 1 << POS_FRAC_BITS;

	localparam int NODE_XY_W = 6;
	localparam int NODE_Z_W  = 5;
	localparam int POS_XY_W  = 14;
	localparam int POS_Z_W   = 13;
	localparam int COMP_W    = 32;

	// integer part of a position, and room for the grid limit compare
	localparam int BASE_W = POS_XY_W - POS_FRAC_BITS;
	localparam int LIM_W  = BASE_W + 2;

	// weights are exact integers at scale 2^W_SHIFT, magnitude up to 2^W_SHIFT
	localparam int W_SHIFT  = 2 * POS_FRAC_BITS + 1;
	localparam int WEIGHT_W = W_SHIFT + 2;
	localparam int PROD_W   = COMP_W + WEIGHT_W;
	localparam int ACC_W    = PROD_W + 2;

	localparam int NODE_COUNT = GRID_NX * GRID_NY * GRID_NZ;
	localparam int ADDR_W     = $clog2(NODE_COUNT);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic signed [COMP_W-1:0]   comp_t;
	typedef comp_t [2:0]                vec3_t;
	typedef logic signed [WEIGHT_W-1:0] weight_t;

	typedef enum logic [1:0] {
		DEST_YV,
		DEST_XV,
		DEST_OUT
	} dest_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		dest_t      dest;
		logic [1:0] idx;
	} mac_ctl_t;

	typedef struct packed {
		logic       busy;
		logic       valid;
		dest_t      dest;
		logic [1:0] idx;
		vec3_t      value;
	} mac_res_t;

	typedef struct packed {
		logic              ok;
		logic [BASE_W-1:0] base;
		weight_t [2:0]     w;
	} axis_t;

	typedef struct packed {
		logic                 operation;
		logic [NODE_XY_W-1:0] node_x;
		logic [NODE_XY_W-1:0] node_y;
		logic [NODE_Z_W-1:0]  node_z;
		logic signed [COMP_W-1:0] load_bx;
		logic signed [COMP_W-1:0] load_by;
		logic signed [COMP_W-1:0] load_bz;
		logic [POS_XY_W-1:0]  pos_x;
		logic [POS_XY_W-1:0]  pos_y;
		logic [POS_Z_W-1:0]   pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] out_bx;
		logic signed [COMP_W-1:0] out_by;
		logic signed [COMP_W-1:0] out_bz;
		logic                     off_grid;
	} out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/gvi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gvi_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 131072
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/gvi_axis.sv @@
// Per-axis setup: first node, range check and Lagrange weights.
`timescale 1ns / 1ps
`default_nettype none

module gvi_axis (
	input  wire logic [gvi_pkg::POS_XY_W-1:0] p,
	input  wire logic [gvi_pkg::LIM_W-1:0]    n,
	input  wire logic                         quad,
	output gvi_pkg::axis_t                    res
);

	import gvi_pkg::*;

	localparam int F = POS_FRAC_BITS;
	localparam weight_t SCALE_W  = weight_t'(POS_SCALE);
	localparam weight_t SCALE_SQ = weight_t'(1) <<< (2 * F);

	logic [BASE_W-1:0]   i_lin;
	logic [F-1:0]        frac;
	logic [F:0]          s_minus_f;
	logic [POS_XY_W:0]   p_round;
	logic [BASE_W:0]     c;
	logic signed [F:0]   d;
	weight_t             dw, dm, dp, d2;

	always_comb begin
		i_lin     = p[POS_XY_W-1:F];
		frac      = p[F-1:0];
		s_minus_f = (F+1)'(POS_SCALE) - {1'b0, frac};
		p_round   = {1'b0, p} + (POS_XY_W+1)'(POS_SCALE / 2);
		c         = p_round[POS_XY_W:F];
		// offset from the rounded node, in [-S/2, S/2)
		d         = $signed(p[F:0] - {c[0], {F{1'b0}}});
		dw        = weight_t'(d);
		dm        = dw - SCALE_W;
		dp        = dw + SCALE_W;
		d2        = dw * dw;

		if (quad) begin
			res.ok   = (c != '0) && ((LIM_W'(c) + LIM_W'(1)) < n);
			res.base = BASE_W'(c - (BASE_W+1)'(1));
			res.w[0] = dw * dm;
			res.w[1] = (SCALE_SQ - d2) <<< 1;
			res.w[2] = dw * dp;
		end else begin
			res.ok   = (LIM_W'(i_lin) + LIM_W'(1)) < n;
			res.base = i_lin;
			res.w[0] = weight_t'({s_minus_f, {(F+1){1'b0}}});
			res.w[1] = weight_t'({1'b0, frac, {(F+1){1'b0}}});
			res.w[2] = '0;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/gvi_mac.sv @@
// Three-lane multiply-accumulate with round-to-nearest and saturation.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gvi_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gvi_pkg::mac_ctl_t ctl,
	input  wire gvi_pkg::vec3_t    opnd,
	input  wire gvi_pkg::weight_t  weight,
	output gvi_pkg::mac_res_t      res
);

	import gvi_pkg::*;

	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (W_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) <<< (COMP_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) <<< (COMP_W - 1));

	mac_ctl_t                  ctl_s2, ctl_s3;
	logic signed [PROD_W-1:0]  prod_s2 [3];
	logic signed [ACC_W-1:0]   acc_q [3];
	logic signed [ACC_W-1:0]   rnd [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (ctl.valid) begin
				prod_s2[k] <= PROD_W'($signed(opnd[k])) * PROD_W'(weight);
			end
			if (ctl_s2.valid) begin
				acc_q[k] <= (ctl_s2.first ? ACC_W'(0) : acc_q[k]) + ACC_W'(prod_s2[k]);
			end
		end
	end

	always_comb begin
		res.busy  = ctl_s2.valid | ctl_s3.valid;
		res.valid = ctl_s3.valid & ctl_s3.last;
		res.dest  = ctl_s3.dest;
		res.idx   = ctl_s3.idx;
		for (int k = 0; k < 3; k++) begin
			rnd[k] = (acc_q[k] + HALF) >>> W_SHIFT;
			if (rnd[k] > SAT_MAX) begin
				res.value[k] = SAT_MAX[COMP_W-1:0];
			end else if (rnd[k] < SAT_MIN) begin
				res.value[k] = SAT_MIN[COMP_W-1:0];
			end else begin
				res.value[k] = rnd[k][COMP_W-1:0];
			end
		end
	end

	// a sum group opens only after the previous one has closed
	`GVI_ASSERT_IMPLIES(a_group_open, ctl.valid && ctl.first, !ctl_s2.valid || ctl_s2.last,
		"mac group opened while another was still accumulating")
	// terms of one group arrive back to back
	`GVI_ASSERT_IMPLIES(a_group_cont, ctl.valid && !ctl.first, ctl_s2.valid && !ctl_s2.last,
		"mac term without an open group ahead of it")
	// an accepted term keeps the unit busy on the next cycle
	`GVI_ASSERT_NEXT(a_term_busy, ctl.valid, res.busy,
		"mac term dropped from the pipeline")

endmodule

`default_nettype wire

@@ hw/rtl/grid_lagrange_vector_interp_top.sv @@
// Top level of the 3D grid vector interpolator: grid memory, sequencer, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Holds a 64x64x32 grid of three-component Q24.8 vectors in one RAM and returns
// trilinear (interp_order 0) or triquadratic (interp_order 1) Lagrange
// interpolation at a Q.8 grid position, interpolating along z, then y, then x,
// each 1D pass rounded to nearest and saturated to 32 bits. A load transaction
// writes one node. A query transaction reads one node per cycle from the grid
// RAM into a shared three-lane multiply-accumulate unit, with a drain of that
// unit's pipeline before each y and x pass and before the result, and the input
// accepts again in the same cycle that the result is presented. A query whose
// nodes fall outside the grid returns off_grid with zero components. The input
// stalls while a query is in progress; a finished result waits in the output
// register, which adds its stall time to the query. A node must be loaded
// before any query reads it.
module grid_lagrange_vector_interp_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire gvi_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output gvi_pkg::out_item_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata
);

	import gvi_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_Z,
		PH_Y,
		PH_X
	} phase_t;

	typedef enum logic [1:0] {
		SRC_NODE,
		SRC_YV,
		SRC_XV
	} src_t;

	typedef struct packed {
		src_t       src;
		logic [1:0] idx;
		weight_t    w;
		mac_ctl_t   ctl;
	} op_t;

	function automatic logic [ADDR_W-1:0] node_addr(
		input logic [BASE_W-1:0] x,
		input logic [BASE_W-1:0] y,
		input logic [BASE_W-1:0] z
	);
		return ADDR_W'((int'(z) * GRID_NY + int'(y)) * GRID_NX + int'(x));
	endfunction

	state_t  state_q;
	phase_t  phase_q;
	logic    order_q, quad_q, oor_q;
	logic [1:0] ix_q, iy_q, iz_q;
	op_t     op_s1;
	logic    out_valid_q;
	out_item_t out_q;

	logic [POS_XY_W-1:0] px_q, py_q;
	logic [POS_Z_W-1:0]  pz_q;
	logic [BASE_W-1:0]   bx_q, by_q, bz_q;
	weight_t             wx_q [3];
	weight_t             wy_q [3];
	weight_t             wz_q [3];
	vec3_t               yv_q [3];
	vec3_t               xv_q [3];
	vec3_t               res_q;

	axis_t     ax_x, ax_y, ax_z;
	mac_res_t  mres;
	mac_ctl_t  mctl;
	vec3_t     opnd;
	logic      in_accept, ram_we, busy, issue, dep;
	logic [1:0] last_idx;
	op_t       iss;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [3*COMP_W-1:0] rdata;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign ram_we = in_accept && (in_data.operation == OP_LOAD) &&
		(int'(in_data.node_x) < GRID_NX) && (int'(in_data.node_y) < GRID_NY) &&
		(int'(in_data.node_z) < GRID_NZ);
	assign waddr = node_addr(BASE_W'(in_data.node_x), BASE_W'(in_data.node_y),
		BASE_W'(in_data.node_z));

	gvi_ram #(
		.WIDTH (3 * COMP_W),
		.DEPTH (NODE_COUNT)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata ({in_data.load_bz, in_data.load_by, in_data.load_bx}),
		.raddr (raddr),
		.rdata (rdata)
	);

	gvi_axis u_ax_x (.p(px_q), .n(LIM_W'(GRID_NX)), .quad(quad_q), .res(ax_x));
	gvi_axis u_ax_y (.p(py_q), .n(LIM_W'(GRID_NY)), .quad(quad_q), .res(ax_y));
	gvi_axis u_ax_z (.p(POS_XY_W'(pz_q)), .n(LIM_W'(GRID_NZ)), .quad(quad_q), .res(ax_z));

	assign busy     = op_s1.ctl.valid | mres.busy;
	assign last_idx = quad_q ? 2'd2 : 2'd1;

	// next operation of the sequence
	always_comb begin
		iss = '0;
		dep = 1'b0;
		case (phase_q)
			PH_Y: begin
				iss.src       = SRC_YV;
				iss.idx       = iy_q;
				iss.w         = wy_q[iy_q];
				iss.ctl.first = (iy_q == 2'd0);
				iss.ctl.last  = (iy_q == last_idx);
				iss.ctl.dest  = DEST_XV;
				iss.ctl.idx   = ix_q;
				dep           = 1'b1;
			end
			PH_X: begin
				iss.src       = SRC_XV;
				iss.idx       = ix_q;
				iss.w         = wx_q[ix_q];
				iss.ctl.first = (ix_q == 2'd0);
				iss.ctl.last  = (ix_q == last_idx);
				iss.ctl.dest  = DEST_OUT;
				iss.ctl.idx   = 2'd0;
				dep           = 1'b1;
			end
			default: begin
				iss.src       = SRC_NODE;
				iss.idx       = iz_q;
				iss.w         = wz_q[iz_q];
				iss.ctl.first = (iz_q == 2'd0);
				iss.ctl.last  = (iz_q == last_idx);
				iss.ctl.dest  = DEST_YV;
				iss.ctl.idx   = iy_q;
			end
		endcase
		// y and x passes read partial sums that must have landed first
		issue         = (state_q == ST_RUN) && !(dep && iss.ctl.first && busy);
		iss.ctl.valid = issue;
	end

	assign raddr = node_addr(bx_q + BASE_W'(ix_q), by_q + BASE_W'(iy_q), bz_q + BASE_W'(iz_q));

	always_comb begin
		case (op_s1.src)
			SRC_YV:  opnd = yv_q[op_s1.idx];
			SRC_XV:  opnd = xv_q[op_s1.idx];
			default: opnd = rdata;
		endcase
		mctl = op_s1.ctl;
	end

	gvi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.opnd   (opnd),
		.weight (op_s1.w),
		.res    (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_Z;
			order_q     <= 1'b0;
			quad_q      <= 1'b0;
			oor_q       <= 1'b0;
			ix_q        <= '0;
			iy_q        <= '0;
			iz_q        <= '0;
			op_s1       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			op_s1 <= iss;
			// the output stage reloads the register itself
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && in_data.operation == OP_QUERY) begin
						quad_q  <= order_q;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					ix_q    <= '0;
					iy_q    <= '0;
					iz_q    <= '0;
					phase_q <= PH_Z;
					if (ax_x.ok && ax_y.ok && ax_z.ok) begin
						state_q <= ST_RUN;
					end else begin
						oor_q   <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_RUN: begin
					if (issue) begin
						case (phase_q)
							PH_Y: begin
								if (iy_q == last_idx) begin
									iy_q <= '0;
									if (ix_q == last_idx) begin
										ix_q    <= '0;
										phase_q <= PH_X;
									end else begin
										ix_q    <= ix_q + 2'd1;
										phase_q <= PH_Z;
									end
								end else begin
									iy_q <= iy_q + 2'd1;
								end
							end
							PH_X: begin
								if (ix_q == last_idx) begin
									state_q <= ST_DRAIN;
								end else begin
									ix_q <= ix_q + 2'd1;
								end
							end
							default: begin
								if (iz_q == last_idx) begin
									iz_q <= '0;
									if (iy_q == last_idx) begin
										iy_q    <= '0;
										phase_q <= PH_Y;
									end else begin
										iy_q <= iy_q + 2'd1;
									end
								end else begin
									iz_q <= iz_q + 2'd1;
								end
							end
						endcase
					end
				end
				ST_DRAIN: begin
					if (mres.valid && mres.dest == DEST_OUT) begin
						oor_q   <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						out_q.out_bx   <= res_q[0];
						out_q.out_by   <= res_q[1];
						out_q.out_bz   <= res_q[2];
						out_q.off_grid <= oor_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && in_data.operation == OP_QUERY) begin
			px_q <= in_data.pos_x;
			py_q <= in_data.pos_y;
			pz_q <= in_data.pos_z;
		end
		if (state_q == ST_SETUP) begin
			bx_q <= ax_x.base;
			by_q <= ax_y.base;
			bz_q <= ax_z.base;
			for (int k = 0; k < 3; k++) begin
				wx_q[k] <= ax_x.w[k];
				wy_q[k] <= ax_y.w[k];
				wz_q[k] <= ax_z.w[k];
			end
			res_q <= '0;
		end
		if (mres.valid) begin
			case (mres.dest)
				DEST_YV:  yv_q[mres.idx] <= mres.value;
				DEST_XV:  xv_q[mres.idx] <= mres.value;
				DEST_OUT: res_q <= mres.value;
				default: ;
			endcase
		end
	end

	`GVI_ASSERT_IMPLIES(a_final_in_drain, mres.valid && mres.dest == DEST_OUT,
		state_q == ST_DRAIN, "final x sum outside the drain state")
	`GVI_ASSERT_NEXT(a_final_to_out, state_q == ST_DRAIN && mres.valid && mres.dest == DEST_OUT,
		state_q == ST_OUT && !oor_q, "final x sum not handed to the output stage")
	`GVI_ASSERT_IMPLIES(a_out_drained, state_q == ST_OUT, !busy,
		"result presented while the mac pipeline still holds terms")

endmodule

`default_nettype wire
